// ===== rtl/mrwt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared types for the Miller-Rabin witness test core: controller states,
// multiplier operand selects, command and status bundles.
// ----------------------------------------------------------------------------
package mrwt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SPLIT,
    ST_RED_RUN,
    ST_EXP,
    ST_MULR_RUN,
    ST_EXP_SQ,
    ST_SQ_RUN,
    ST_TEST,
    ST_LOOP_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    XSEL_ONE,
    XSEL_R,
    XSEL_SQ
  } xsel_t;

  typedef enum logic {
    YSEL_R,
    YSEL_SQ
  } ysel_t;

  typedef struct packed {
    logic  load;
    logic  split;
    logic  mul_start;
    logic  mul_step;
    xsel_t xsel;
    ysel_t ysel;
    logic  wr_r;
    logic  wr_sq;
    logic  e_shift;
    logic  t_dec;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic n_eq2;
    logic n_odd;
    logic e_lsb;
    logic e_one;
    logic t_zero;
    logic mul_done;
    logic acc_one;
    logic r_one;
    logic r_trivial;
  } status_t;

endpackage

// ===== rtl/mrwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrwt_ctrl
// Sequencer for one test: classification, factoring of n-1, modular
// exponentiation and the squaring loop. Owns the handshakes and result.
// ----------------------------------------------------------------------------
module mrwt_ctrl
  import mrwt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output logic    out_probable_prime,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_res_r, out_res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      res_r       <= 1'b0;
      out_res_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      out_res_r   <= out_res_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.xsel      = XSEL_ONE;
    cmd.ysel      = YSEL_SQ;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (sts.n_lt2) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else if (sts.n_eq2) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (!sts.n_odd) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!sts.e_lsb) begin
          cmd.split = 1'b1;
        end else begin
          // reduce the base: 1 * a mod n
          cmd.mul_start = 1'b1;
          cmd.xsel      = XSEL_ONE;
          cmd.ysel      = YSEL_SQ;
          state_nxt     = ST_RED_RUN;
        end
      end
      ST_RED_RUN: begin
        if (sts.mul_done) begin
          cmd.wr_sq = 1'b1;
          state_nxt = ST_EXP;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_EXP: begin
        if (sts.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.xsel      = XSEL_R;
          cmd.ysel      = YSEL_SQ;
          state_nxt     = ST_MULR_RUN;
        end else begin
          state_nxt = ST_EXP_SQ;
        end
      end
      ST_MULR_RUN: begin
        if (sts.mul_done) begin
          cmd.wr_r  = 1'b1;
          state_nxt = ST_EXP_SQ;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_EXP_SQ: begin
        if (sts.e_one) begin
          state_nxt = ST_TEST;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.xsel      = XSEL_SQ;
          cmd.ysel      = YSEL_SQ;
          cmd.e_shift   = 1'b1;
          state_nxt     = ST_SQ_RUN;
        end
      end
      ST_SQ_RUN: begin
        if (sts.mul_done) begin
          cmd.wr_sq = 1'b1;
          state_nxt = ST_EXP;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_TEST: begin
        if (sts.t_zero) begin
          res_nxt   = sts.r_one;
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.xsel      = XSEL_R;
          cmd.ysel      = YSEL_R;
          cmd.t_dec     = 1'b1;
          state_nxt     = ST_LOOP_RUN;
        end
      end
      ST_LOOP_RUN: begin
        if (sts.mul_done) begin
          if (sts.acc_one && !sts.r_trivial) begin
            // nontrivial square root of one
            res_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            cmd.wr_r  = 1'b1;
            state_nxt = ST_TEST;
          end
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_probable_prime = out_res_r;

endmodule

// ===== rtl/mrwt_dp.sv =====
// ----------------------------------------------------------------------------
// mrwt_dp
// Datapath: operand registers, n-1 factoring shifter and a bit-serial
// shift-add modular multiplier (one multiplier bit per cycle).
// ----------------------------------------------------------------------------
module mrwt_dp
  import mrwt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] cand,
  input  logic [WIDTH-1:0] base,
  input  cmd_t             cmd,
  output status_t          sts
);

  localparam int TW = $clog2(WIDTH);

  logic [WIDTH-1:0] n_r, e_r, r_r, sq_r, acc_r, add_r, mlt_r;
  logic [WIDTH-1:0] n_nxt, e_nxt, r_nxt, sq_nxt, acc_nxt, add_nxt, mlt_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  logic [WIDTH-1:0] x_op, y_op;
  logic [WIDTH:0]   sum_acc, sum_add, dif_acc, dif_add;
  logic [WIDTH-1:0] acc_mod, add_mod;

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    e_r   <= e_nxt;
    r_r   <= r_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    add_r <= add_nxt;
    mlt_r <= mlt_nxt;
    t_r   <= t_nxt;
  end

  always_comb begin
    case (cmd.xsel)
      XSEL_R:  x_op = r_r;
      XSEL_SQ: x_op = sq_r;
      default: x_op = {{(WIDTH-1){1'b0}}, 1'b1};
    endcase
    y_op = (cmd.ysel == YSEL_R) ? r_r : sq_r;
  end

  // modular doubling and accumulation, operands below n
  always_comb begin
    sum_acc = {1'b0, acc_r} + {1'b0, add_r};
    sum_add = {add_r, 1'b0};
    dif_acc = sum_acc - {1'b0, n_r};
    dif_add = sum_add - {1'b0, n_r};
    acc_mod = dif_acc[WIDTH] ? sum_acc[WIDTH-1:0] : dif_acc[WIDTH-1:0];
    add_mod = dif_add[WIDTH] ? sum_add[WIDTH-1:0] : dif_add[WIDTH-1:0];
  end

  always_comb begin
    n_nxt   = n_r;
    e_nxt   = e_r;
    r_nxt   = r_r;
    sq_nxt  = sq_r;
    acc_nxt = acc_r;
    add_nxt = add_r;
    mlt_nxt = mlt_r;
    t_nxt   = t_r;
    if (cmd.load) begin
      n_nxt  = cand;
      e_nxt  = cand - {{(WIDTH-1){1'b0}}, 1'b1};
      r_nxt  = {{(WIDTH-1){1'b0}}, 1'b1};
      sq_nxt = base;
      t_nxt  = '0;
    end
    if (cmd.split) begin
      e_nxt = e_r >> 1;
      t_nxt = t_r + {{(TW-1){1'b0}}, 1'b1};
    end
    if (cmd.e_shift) begin
      e_nxt = e_r >> 1;
    end
    if (cmd.t_dec) begin
      t_nxt = t_r - {{(TW-1){1'b0}}, 1'b1};
    end
    if (cmd.mul_start) begin
      acc_nxt = '0;
      add_nxt = x_op;
      mlt_nxt = y_op;
    end
    if (cmd.mul_step) begin
      if (mlt_r[0]) begin
        acc_nxt = acc_mod;
      end
      add_nxt = add_mod;
      mlt_nxt = mlt_r >> 1;
    end
    if (cmd.wr_r) begin
      r_nxt = acc_r;
    end
    if (cmd.wr_sq) begin
      sq_nxt = acc_r;
    end
  end

  always_comb begin
    sts.n_lt2     = (n_r[WIDTH-1:1] == '0);
    sts.n_eq2     = (n_r == WIDTH'(2));
    sts.n_odd     = n_r[0];
    sts.e_lsb     = e_r[0];
    sts.e_one     = (e_r == WIDTH'(1));
    sts.t_zero    = (t_r == '0);
    sts.mul_done  = (mlt_r == '0);
    sts.acc_one   = (acc_r == WIDTH'(1));
    sts.r_one     = (r_r == WIDTH'(1));
    sts.r_trivial = (r_r == WIDTH'(1)) || (r_r == (n_r - WIDTH'(1)));
  end

endmodule

// ===== rtl/miller_rabin_witness_test_core.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_core
// One Miller-Rabin round: candidate n and witness base a in, one
// probable-prime flag out. Shift-add modular multiplication, one bit a cycle.
// ----------------------------------------------------------------------------
//   channel | ports                             | direction
//   --------+-----------------------------------+----------
//   input   | in_valid/in_stall, candidate,base | in
//   result  | out_valid/out_stall, probable_prime | out
//
// each modular multiply runs on the bit-serial multiplier
// a test runs up to about 2*WIDTH multiplies
// trivial candidates (below 2, even, two) are decided without a multiply
// one test at a time; a new item is taken while the last result waits
// synchronous active-low reset clears the controller and the output valid
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_core
  import mrwt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_candidate,
  input  logic [31:0] in_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_probable_prime
);

  logic [WIDTH-1:0] cand_w, base_w;
  cmd_t             cmd;
  status_t          sts;

  generate
    if (WIDTH > 32) begin : g_ext
      assign cand_w = {{(WIDTH-32){1'b0}}, in_candidate};
      assign base_w = {{(WIDTH-32){1'b0}}, in_base};
    end else if (WIDTH == 32) begin : g_eq
      assign cand_w = in_candidate;
      assign base_w = in_base;
    end else begin : g_cut
      assign cand_w = in_candidate[WIDTH-1:0];
      assign base_w = in_base[WIDTH-1:0];
    end
  endgenerate

  mrwt_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_probable_prime (out_probable_prime),
    .sts                (sts),
    .cmd                (cmd)
  );

  mrwt_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk  (clk),
    .cand (cand_w),
    .base (base_w),
    .cmd  (cmd),
    .sts  (sts)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Miller-Rabin witness test core. A scoreboard
// predicts each verdict from the accepted candidate and base and checks it
// against the result channel. Directed corner cases come first, then random
// candidates: odd numbers, a table of primes and strong pseudoprimes, small
// odd values, special bases and trivial noise. Both sides idle at random and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
class prime_scoreboard;
  bit          verdict_q[$];
  logic [63:0] width_mask;
  int          errors;
  int          checked;
  int          primes_seen;

  function new(int width);
    width_mask  = (64'd1 << width) - 64'd1;
    errors      = 0;
    checked     = 0;
    primes_seen = 0;
  endfunction

  // shift-add modular product
  function logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] addend;
    acc    = 64'd0;
    addend = x % m;
    while (y != 64'd0) begin
      if (y[0]) acc = (acc + addend) % m;
      addend = (addend << 1) % m;
      y      = y >> 1;
    end
    return acc;
  endfunction

  function void note_candidate(logic [31:0] cand, logic [31:0] base);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] odd;
    logic [63:0] y;
    logic [63:0] sq;
    logic [63:0] e;
    int          twos;
    bit          root_hit;
    bit          verdict;
    n = {32'd0, cand} & width_mask;
    a = {32'd0, base} & width_mask;
    if (n < 64'd2) begin
      verdict = 1'b0;
    end else if (n == 64'd2) begin
      verdict = 1'b1;
    end else if (!n[0]) begin
      verdict = 1'b0;
    end else begin
      odd  = n - 64'd1;
      twos = 0;
      while (!odd[0]) begin
        odd = odd >> 1;
        twos++;
      end
      y  = 64'd1;
      sq = a % n;
      e  = odd;
      while (e != 64'd0) begin
        if (e[0]) y = mul_mod(y, sq, n);
        sq = mul_mod(sq, sq, n);
        e  = e >> 1;
      end
      // look for a nontrivial square root of one
      root_hit = 1'b0;
      for (int i = 0; i < twos && !root_hit; i++) begin
        sq = mul_mod(y, y, n);
        if (sq == 64'd1 && y != 64'd1 && y != n - 64'd1) root_hit = 1'b1;
        else y = sq;
      end
      verdict = !root_hit && (y == 64'd1);
    end
    verdict_q.push_back(verdict);
  endfunction

  function void check_verdict(logic actual);
    bit expected_v;
    if (verdict_q.size() == 0) begin
      $error("probable_prime: result with no test pending, expected none, actual %0b", actual);
      errors++;
    end else begin
      expected_v = verdict_q.pop_front();
      checked++;
      if (expected_v) primes_seen++;
      if (actual !== expected_v) begin
        $error("probable_prime mismatch: expected %0b, actual %0b", expected_v, actual);
        errors++;
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUT_WIDTH     = 32;
  localparam int DIRECTED_LEN  = 23;
  localparam int RANDOM_TESTS  = 160;
  localparam int PRIME_TAB_LEN = 20;
  localparam int LONG_HOLD     = 6000;
  localparam int IDLE_LIMIT    = 30000;
  localparam int DRAIN_CYCLES  = 100;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [31:0] in_candidate       = 32'd0;
  logic [31:0] in_base            = 32'd0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic        out_probable_prime;

  prime_scoreboard sb = new(DUT_WIDTH);

  int idle_cycles = 0;
  int tests_sent  = 0;

  logic [31:0] dir_cand [DIRECTED_LEN] = '{
    32'd0, 32'd1, 32'd2, 32'd2, 32'd4, 32'hFFFFFFFE, 32'd3, 32'd3, 32'd3, 32'd7, 32'd7,
    32'd7, 32'd561, 32'd2047, 32'd2047, 32'hFFFFFFFB, 32'hFFFFFFFB, 32'hFFFFFFFB,
    32'hFFFFFFFF, 32'h80000001, 32'd15, 32'd25, 32'd3215031751
  };
  logic [31:0] dir_base [DIRECTED_LEN] = '{
    32'd5, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd3, 32'd3, 32'd2, 32'd0, 32'd3, 32'd6, 32'd1,
    32'd3, 32'd2, 32'd2, 32'd3, 32'd2, 32'hFFFFFFFA, 32'hFFFFFFFF,
    32'd3, 32'h12345678, 32'hFFFFFFFF, 32'd50, 32'd7
  };

  // primes, plus strong pseudoprimes that pass some bases
  logic [31:0] prime_tab [PRIME_TAB_LEN] = '{
    32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd101, 32'd65537, 32'd2147483647,
    32'd4294967291, 32'd4294967279, 32'd1000000007, 32'd998244353, 32'd3221225473,
    32'd2013265921, 32'd469762049, 32'd167772161, 32'd2047, 32'd1373653,
    32'd25326001, 32'd3215031751
  };

  miller_rabin_witness_test_core #(
    .WIDTH(DUT_WIDTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_candidate      (in_candidate),
    .in_base           (in_base),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_probable_prime(out_probable_prime)
  );

  always #5 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_candidate(in_candidate, in_base);
      if (out_valid && !out_stall) sb.check_verdict(out_probable_prime);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_test(input logic [31:0] cand, input logic [31:0] base, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_candidate <= cand;
    in_base      <= base;
    do @(posedge clk); while (in_stall);
    tests_sent++;
  endtask

  // result side stalls
  initial begin
    int wait_cycles;
    bit held;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && sb.checked >= 40) begin
        held        = 1'b1;
        wait_cycles = LONG_HOLD;
      end else if (sb.checked >= 110 && sb.checked < 140) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(5);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int          kind;
    int          bmode;
    logic [31:0] cand;
    logic [31:0] base;
    logic [31:0] k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_LEN; i++) send_test(dir_cand[i], dir_base[i], 1'b0);

    for (int i = 0; i < RANDOM_TESTS; i++) begin
      kind = $urandom_range(9);
      cand = $urandom | 32'd1;
      base = $urandom;
      case (kind)
        4, 5, 6: cand = prime_tab[$urandom_range(PRIME_TAB_LEN - 1)];
        7:       cand = $urandom_range(255, 3) | 32'd1;
        8: begin
          if ($urandom_range(3) == 0) cand = $urandom_range(2);
          else cand = $urandom & ~32'd1;
        end
        9:       cand = $urandom;
        default: ;
      endcase
      if (kind >= 4 && kind <= 7) begin
        bmode = $urandom_range(5);
        case (bmode)
          0: base = 32'd1;
          1: base = cand - 32'd1;
          2: begin
            k    = $urandom_range(32'hFFFFFFFF / cand);
            base = k * cand;
          end
          default: ;
        endcase
      end
      send_test(cand, base, i >= 60 && i < 90);
    end
    in_valid <= 1'b0;

    while (sb.checked < tests_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d tests: %0d probable primes, %0d composites", tests_sent,
             sb.primes_seen, sb.checked - sb.primes_seen);
    $display("directed corners, prime and pseudoprime table, special bases, long output hold");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/mrwt_pkg.sv
rtl/mrwt_ctrl.sv
rtl/mrwt_dp.sv
rtl/miller_rabin_witness_test_core.sv
tb/tb.sv
